// ===== sv/ecc_pkg.sv =====
// Shared types, constants and tables for the epoch/calendar converter.
`timescale 1ns / 1ps
package ecc_pkg;

  typedef enum logic {
    REQ_TO_CAL   = 1'b0,
    REQ_TO_EPOCH = 1'b1
  } ecc_req_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] epoch_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } ecc_in_t;

  typedef struct packed {
    logic [31:0] epoch_out;
    logic [7:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday;
  } ecc_out_t;

  // register stages through either conversion path
  localparam int unsigned PipeDepth = 8;

  localparam logic [31:0] Secs1970To2000 = 32'd946684800;
  localparam logic [16:0] SecsPerDay     = 17'd86400;
  localparam logic [11:0] SecsPerHour    = 12'd3600;
  localparam logic [5:0]  SecsPerMin     = 6'd60;
  localparam logic [11:0] BaseYear       = 12'd2000;
  localparam logic [8:0]  DaysPerYear    = 9'd365;
  localparam logic [10:0] DaysPerCycle   = 11'd1461;

  // reciprocals: floor(x / d) = (x * M) >> S, exact over the used range
  localparam logic [25:0] DayRecip   = 26'd50903317; // (t>>7)/675, S=35
  localparam logic [17:0] HourRecip  = 18'd149131;   // /3600, S=29
  localparam logic [16:0] CycleRecip = 17'd91868;    // /1461, S=27
  localparam logic [12:0] MinRecip   = 13'd4370;     // /60, S=18
  localparam logic [22:0] WdRecip    = 23'd4793491;  // /7, S=25

  // days in the months before month m (months above 12 act as December)
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

  // first day-of-year of month m, leap day included after February
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    return days_before(m) + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== sv/epoch_calendar_converter.sv =====
// Epoch/calendar converter: an accepted input's result is valid when it leaves the last stage.
// Throughput: one transaction per cycle; the eight-stage pipeline advances whenever
// the output register is empty or its result is being taken.
// Reset clears only the valid bits; payload registers are not reset.
// No clearing pass after reset: inputs are accepted as soon as reset is released.
`timescale 1ns / 1ps
module epoch_calendar_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ecc_pkg::ecc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ecc_pkg::ecc_out_t out_data_o
);
  import ecc_pkg::*;

  // valid and request type travel alongside the two datapaths
  logic [PipeDepth-1:0] vld_q, vld_d;
  ecc_req_e             req_q [PipeDepth];
  logic                 en;
  ecc_out_t             cal_res, ep_res;

  // whole pipe moves together; it only halts when the last stage holds a
  // result the consumer is not taking
  assign en         = !(vld_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o = !en;

  assign vld_d = en ? {vld_q[PipeDepth-2:0], in_valid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req_q[0] <= ecc_req_e'(in_data_i.req_type);
      for (int i = 1; i < PipeDepth; i++) req_q[i] <= req_q[i-1];
    end
  end

  // both directions compute on every transaction; the request type selects
  ecc_e2c u_e2c (
    .clk_i   (clk_i),
    .en_i    (en),
    .epoch_i (in_data_i.epoch_in),
    .res_o   (cal_res)
  );

  ecc_c2e u_c2e (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (in_data_i),
    .res_o (ep_res)
  );

  always_comb begin
    unique case (req_q[PipeDepth-1])
      REQ_TO_CAL:   out_data_o = cal_res;
      REQ_TO_EPOCH: out_data_o = ep_res;
      default:      out_data_o = cal_res;
    endcase
  end

  assign out_valid_o = vld_q[PipeDepth-1];
endmodule

// ===== sv/ecc_weekday.sv =====
// Three-stage weekday unit: (days + 6) mod 7 mapped to 1..7.
`timescale 1ns / 1ps
module ecc_weekday (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [21:0] days_i,
  output logic [2:0]         weekday_o
);
  import ecc_pkg::*;

  logic [21:0] x_q, x2_q;
  logic [18:0] q_q;
  logic [2:0]  wd_q;
  logic [44:0] prod;
  logic [21:0] r;

  assign prod = 45'(x_q) * 45'(WdRecip);
  assign r    = x2_q - 22'({3'b0, q_q} * 22'd7);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= days_i + 22'sd6;
      q_q  <= prod[43:25];
      x2_q <= x_q;
      wd_q <= (r[2:0] == 3'd0) ? 3'd7 : r[2:0];
    end
  end

  assign weekday_o = wd_q;
endmodule

// ===== sv/ecc_e2c.sv =====
// Epoch to calendar pipeline, eight stages.
`timescale 1ns / 1ps
module ecc_e2c (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       epoch_i,
  output ecc_pkg::ecc_out_t res_o
);
  import ecc_pkg::*;

  logic [31:0] e1_q, e2_q, e3_q, e4_q, e5_q, e6_q, e7_q, e8_q;
  logic [31:0] t1_q, t2_q;
  logic [15:0] dq2_q, days3_q, days4_q;
  logic [16:0] rem3_q, rem4_q;
  logic [4:0]  hr4_q, hr5_q, hr6_q, hr7_q, hr8_q;
  logic [4:0]  cyc4_q, cyc5_q, cyc6_q;
  logic [11:0] ms5_q, ms6_q;
  logic [10:0] r5_q;
  logic [5:0]  mn6_q, mn7_q, mn8_q, sec7_q, sec8_q;
  logic [1:0]  yc6_q;
  logic [8:0]  doy6_q, doy7_q;
  logic        leap6_q, leap7_q;
  logic [6:0]  yr7_q, yr8_q;
  logic [3:0]  mo7_q, mo8_q;
  logic [4:0]  day8_q;
  logic [2:0]  wd7_q, wd8_q, wd_w;

  logic [50:0] p_day;
  logic [34:0] p_hr;
  logic [32:0] p_cyc;
  logic [24:0] p_mn;
  logic [10:0] rr;
  logic [3:0]  mo_cnt;

  assign p_day = 51'(t1_q[31:7]) * 51'(DayRecip);
  assign p_hr  = 35'(rem3_q) * 35'(HourRecip);
  assign p_cyc = 33'(days3_q) * 33'(CycleRecip);
  assign p_mn  = 25'(ms5_q) * 25'(MinRecip);
  assign rr    = r5_q - 11'd366;

  always_comb begin
    mo_cnt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy6_q >= month_start(4'(k), leap6_q)) mo_cnt = mo_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1: shift origin to 2000, clamp earlier epochs
      e1_q   <= epoch_i;
      t1_q   <= (epoch_i < Secs1970To2000) ? 32'd0 : epoch_i - Secs1970To2000;
      // 2: day number
      e2_q   <= e1_q;
      t2_q   <= t1_q;
      dq2_q  <= p_day[50:35];
      // 3: seconds of day
      e3_q    <= e2_q;
      days3_q <= dq2_q;
      rem3_q  <= 17'(t2_q - 32'(dq2_q) * 32'(SecsPerDay));
      // 4: hour, four-year cycle
      e4_q    <= e3_q;
      rem4_q  <= rem3_q;
      days4_q <= days3_q;
      hr4_q   <= p_hr[33:29];
      cyc4_q  <= p_cyc[31:27];
      // 5: seconds of hour, day in cycle
      e5_q   <= e4_q;
      hr5_q  <= hr4_q;
      cyc5_q <= cyc4_q;
      ms5_q  <= 12'(rem4_q - 17'(hr4_q) * 17'(SecsPerHour));
      r5_q   <= 11'(days4_q - 16'(cyc4_q) * 16'(DaysPerCycle));
      // 6: minute, year in cycle
      e6_q   <= e5_q;
      hr6_q  <= hr5_q;
      cyc6_q <= cyc5_q;
      ms6_q  <= ms5_q;
      mn6_q  <= p_mn[23:18];
      if (r5_q < 11'd366) begin
        yc6_q <= 2'd0; doy6_q <= r5_q[8:0]; leap6_q <= 1'b1;
      end else if (rr < 11'd365) begin
        yc6_q <= 2'd1; doy6_q <= rr[8:0]; leap6_q <= 1'b0;
      end else if (rr < 11'd730) begin
        yc6_q <= 2'd2; doy6_q <= 9'(rr - 11'd365); leap6_q <= 1'b0;
      end else begin
        yc6_q <= 2'd3; doy6_q <= 9'(rr - 11'd730); leap6_q <= 1'b0;
      end
      // 7: second, month
      e7_q    <= e6_q;
      hr7_q   <= hr6_q;
      mn7_q   <= mn6_q;
      sec7_q  <= 6'(ms6_q - 12'(mn6_q) * 12'(SecsPerMin));
      yr7_q   <= {cyc6_q, yc6_q};
      mo7_q   <= mo_cnt;
      doy7_q  <= doy6_q;
      leap7_q <= leap6_q;
      wd7_q   <= wd_w;
      // 8: day of month
      e8_q   <= e7_q;
      hr8_q  <= hr7_q;
      mn8_q  <= mn7_q;
      sec8_q <= sec7_q;
      yr8_q  <= yr7_q;
      mo8_q  <= mo7_q;
      day8_q <= 5'(doy7_q - month_start(mo7_q, leap7_q) + 9'd1);
      wd8_q  <= wd7_q;
    end
  end

  // weekday enters after stage 3, leaves after stage 6
  ecc_weekday u_wd (
    .clk_i     (clk_i),
    .en_i      (en_i),
    .days_i    (signed'(22'(days3_q))),
    .weekday_o (wd_w)
  );

  assign res_o.epoch_out  = e8_q;
  assign res_o.year_out   = 8'(yr8_q);
  assign res_o.month_out  = mo8_q;
  assign res_o.day_out    = day8_q;
  assign res_o.hour_out   = hr8_q;
  assign res_o.minute_out = mn8_q;
  assign res_o.second_out = sec8_q;
  assign res_o.weekday    = wd8_q;
endmodule

// ===== sv/ecc_c2e.sv =====
// Calendar to epoch pipeline, eight stages.
`timescale 1ns / 1ps
module ecc_c2e (
  input  logic              clk_i,
  input  logic              en_i,
  input  ecc_pkg::ecc_in_t  req_i,
  output ecc_pkg::ecc_out_t res_o
);
  import ecc_pkg::*;

  ecc_out_t          echo_q [PipeDepth];
  logic [11:0]       y1_q;
  logic [3:0]        m1_q;
  logic [4:0]        d1_q;
  logic [16:0]       hms1_q, hms2_q, hms3_q, hms4_q;
  logic [19:0]       yd2_q;
  logic [8:0]        md2_q;
  logic signed [21:0] days3_q;
  logic [31:0]       dsec4_q, ep5_q, ep6_q, ep7_q, ep8_q;
  logic [2:0]        wd7_q, wd8_q, wd_w;
  logic [11:0]       y_adj;

  assign y_adj = (req_i.year_in >= BaseYear) ? req_i.year_in - BaseYear : req_i.year_in;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 1: year offset, time of day in seconds
      echo_q[0].epoch_out  <= '0;
      echo_q[0].year_out   <= y_adj[7:0];
      echo_q[0].month_out  <= req_i.month_in;
      echo_q[0].day_out    <= req_i.day_in;
      echo_q[0].hour_out   <= req_i.hour_in;
      echo_q[0].minute_out <= req_i.minute_in;
      echo_q[0].second_out <= req_i.second_in;
      echo_q[0].weekday    <= '0;
      for (int i = 1; i < PipeDepth; i++) echo_q[i] <= echo_q[i-1];
      y1_q   <= y_adj;
      m1_q   <= req_i.month_in;
      d1_q   <= req_i.day_in;
      hms1_q <= 17'(req_i.hour_in) * 17'(SecsPerHour)
              + 17'(req_i.minute_in) * 17'(SecsPerMin) + 17'(req_i.second_in);
      // 2: days of whole years, days within year
      yd2_q  <= 20'(y1_q) * 20'(DaysPerYear) + 20'((y1_q + 12'd3) >> 2);
      md2_q  <= 9'(d1_q) + days_before(m1_q)
              + (((m1_q > 4'd2) && (y1_q[1:0] == 2'd0)) ? 9'd1 : 9'd0);
      hms2_q <= hms1_q;
      // 3: day count since 2000-01-01, may be -1
      days3_q <= signed'(22'(yd2_q)) + signed'(22'(md2_q)) - 22'sd1;
      hms3_q  <= hms2_q;
      // 4: day count in seconds, modulo 2^32 (sign extended so -1 wraps)
      dsec4_q <= unsigned'(32'(days3_q)) * 32'(SecsPerDay);
      hms4_q  <= hms3_q;
      // 5: add time of day and origin
      ep5_q <= dsec4_q + 32'(hms4_q) + Secs1970To2000;
      ep6_q <= ep5_q;
      ep7_q <= ep6_q;
      ep8_q <= ep7_q;
      wd7_q <= wd_w;
      wd8_q <= wd7_q;
    end
  end

  ecc_weekday u_wd (
    .clk_i     (clk_i),
    .en_i      (en_i),
    .days_i    (days3_q),
    .weekday_o (wd_w)
  );

  always_comb begin
    res_o           = echo_q[PipeDepth-1];
    res_o.epoch_out = ep8_q;
    res_o.weekday   = wd8_q;
  end
endmodule

// ===== test/epoch_calendar_converter_test.sv =====
// Testbench for the epoch/calendar converter: directed and random conversions checked in order.
`timescale 1ns / 1ps
module epoch_calendar_converter_test;
  import ecc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam longint unsigned EpochOf2000 = 64'd946684800;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  ecc_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ecc_out_t out_data_o;

  ecc_out_t    expected_dates[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          allow_idle = 1'b1;

  always #6 clk_i = ~clk_i;

  epoch_calendar_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // weekday from a day count since 2000-01-01 (a Saturday)
  function automatic logic [2:0] day_of_week(input longint days);
    longint w;
    w = ((days + 6) % 7 + 7) % 7;
    return (w == 0) ? 3'd7 : w[2:0];
  endfunction

  function automatic ecc_out_t convert_date(input ecc_in_t req);
    ecc_out_t   res;
    logic [31:0] t, days, total, mlen;
    logic [31:0] yr, mo;
    logic        leap;
    longint      dcount, secs, y;
    int          before_month [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                       334, 334, 334, 334};
    int          month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    res = '0;
    if (req.req_type == REQ_TO_CAL) begin
      t = (req.epoch_in < EpochOf2000) ? 32'd0 : req.epoch_in - EpochOf2000[31:0];
      res.second_out = 6'(t % 32'd60); t = t / 32'd60;
      res.minute_out = 6'(t % 32'd60); t = t / 32'd60;
      res.hour_out = 5'(t % 32'd24);
      days = t / 32'd24;
      total = days;
      yr = 0;
      forever begin
        leap = (yr % 4 == 0);
        if (days < 365 + leap) break;
        days -= 365 + leap;
        yr++;
      end
      for (mo = 1; mo < 12; mo++) begin
        mlen = month_days[mo - 1] + ((leap && mo == 2) ? 1 : 0);
        if (days < mlen) break;
        days -= mlen;
      end
      res.epoch_out = req.epoch_in;
      res.year_out = yr[7:0];
      res.month_out = mo[3:0];
      res.day_out = days[4:0] + 5'd1;
      res.weekday = day_of_week(longint'(total));
    end else begin
      y = longint'(req.year_in);
      if (y >= 2000) y -= 2000;
      dcount = longint'(req.day_in) + longint'(before_month[req.month_in]);
      if (req.month_in > 2 && y % 4 == 0) dcount++;
      dcount += 365 * y + (y + 3) / 4 - 1;
      secs = ((dcount * 24 + longint'(req.hour_in)) * 60 + longint'(req.minute_in)) * 60
             + longint'(req.second_in) + EpochOf2000;
      res.epoch_out = secs[31:0];
      res.year_out = y[7:0];
      res.month_out = req.month_in;
      res.day_out = req.day_in;
      res.hour_out = req.hour_in;
      res.minute_out = req.minute_in;
      res.second_out = req.second_in;
      res.weekday = day_of_week(dcount);
    end
    return res;
  endfunction

  // one transaction on the input channel, with an optional random gap first;
  // valid stays high after acceptance so back-to-back sends drive it once
  task automatic send_request(input ecc_in_t req);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    expected_dates.push_back(convert_date(req));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic ecc_in_t epoch_req(input logic [31:0] e);
    ecc_in_t r;
    r = '0;
    r.req_type = REQ_TO_CAL;
    r.epoch_in = e;
    r.year_in = 12'($urandom);
    return r;
  endfunction

  function automatic ecc_in_t date_req(input logic [11:0] y, input logic [3:0] m,
                                       input logic [4:0] d, input logic [4:0] h,
                                       input logic [5:0] mi, input logic [5:0] s);
    ecc_in_t r;
    r.req_type = REQ_TO_EPOCH;
    r.epoch_in = $urandom;
    r.year_in = y; r.month_in = m; r.day_in = d;
    r.hour_in = h; r.minute_in = mi; r.second_in = s;
    return r;
  endfunction

  // output side: random stall bursts, in-order compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          error_count++;
        end else begin
          ecc_out_t want;
          want = expected_dates.pop_front();
          if (want !== out_data_o) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data_o);
            error_count++;
          end
        end
      end
      if (out_stall_i) begin
        if (!allow_idle || stall_left <= 1) out_stall_i <= 1'b0;
        else stall_left--;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 11);
      end
    end
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("epoch_calendar_converter test failed");
      $finish;
    end
  end

  task automatic test_epoch_edges();
    send_request(epoch_req(32'd0));
    send_request(epoch_req(32'd946684799));
    send_request(epoch_req(32'd946684800));
    send_request(epoch_req(32'd951782400));   // 2000-02-29
    send_request(epoch_req(32'd4102444800));  // 2100-01-01
    send_request(epoch_req(32'd4107542400));  // 2100-02-29 under the 4-year rule
    send_request(epoch_req(32'hFFFF_FFFF));
    send_request(epoch_req(32'h8000_0000));
  endtask

  task automatic test_date_edges();
    send_request(date_req(12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_request(date_req(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send_request(date_req(12'd2136, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
    send_request(date_req(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0));    // month and day zero
    send_request(date_req(12'd4, 4'd3, 5'd1, 5'd12, 6'd30, 6'd30)); // after a leap day
    send_request(date_req(12'd5, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
    send_request(date_req(12'hFFF, 4'd13, 5'd31, 5'd31, 6'd63, 6'd63));
    send_request(date_req(12'd1999, 4'd2, 5'd29, 5'd0, 6'd0, 6'd1));
    send_request(date_req(12'd100, 4'd2, 5'd29, 5'd1, 6'd2, 6'd3));
  endtask

  task automatic test_random_mix(input int unsigned count);
    ecc_in_t r;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: r = epoch_req($urandom);
        1: r = epoch_req($urandom_range(946684800, 32'hFFFF_FFFF));
        2: r = date_req(12'($urandom_range(0, 136)), 4'($urandom_range(1, 12)),
                        5'($urandom_range(1, 28)), 5'($urandom_range(0, 23)),
                        6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        3: r = date_req(12'($urandom_range(2000, 2136)), 4'($urandom_range(1, 12)),
                        5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                        6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        default: r = date_req(12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                              6'($urandom), 6'($urandom));
      endcase
      send_request(r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_epoch_edges();
    test_date_edges();
    test_random_mix(1300);
    // last stretch runs back to back with no stalls
    allow_idle = 1'b0;
    test_random_mix(150);
    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("epoch_calendar_converter test passed");
    end else begin
      $display("epoch_calendar_converter test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ecc_pkg.sv
sv/ecc_weekday.sv
sv/ecc_e2c.sv
sv/ecc_c2e.sv
sv/epoch_calendar_converter.sv
test/epoch_calendar_converter_test.sv
